// ----- design/mrtl_pkg.sv -----
package mrtl_pkg;

  // Channel and history geometry
  localparam int CHANNELS      = 6;
  localparam int HISTORY_DEPTH = 15;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam int CH_W          = 3;
  localparam int POS_W         = 4;
  localparam int PLOT_W        = 2;
  localparam int CNT_W         = $clog2(CHANNELS + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int VAL_W    = 15;
  localparam int SUM_W    = 18;
  localparam int ABS_W    = SUM_W - 1;

  // Stream packing
  localparam int S_DATA_W  = 104;
  localparam int S_USER_W  = 3;
  localparam int M_DATA_W  = 64;
  localparam int M_USER_W  = 2;
  localparam int RD_CH_LSB = CHANNELS * SAMPLE_W;
  localparam int POS_LSB   = RD_CH_LSB + CH_W;

  // Scaling: value * 7 / 16, truncated toward zero
  localparam int SCALED_W    = SAMPLE_W + 3;
  localparam int SCALE_MUL   = 7;
  localparam int SCALE_SHIFT = 4;
  localparam int SCALE_BIAS  = (1 << SCALE_SHIFT) - 1;

  // Average: sum / 6 as a reciprocal multiply, exact for |sum| < 2**17
  localparam int RECIP_W    = 16;
  localparam logic [RECIP_W-1:0] DIV6_RECIP = 16'd43691;
  localparam int AVG_SHIFT  = 18;
  localparam int PROD_W     = ABS_W + RECIP_W;

  // Tick schedule
  localparam int TICK_W        = 11;
  localparam int TICKS_PER_ADD = 10;
  localparam int ADDS_PER_HOUR = 6;
  localparam int ADDS_PER_DADD = 24;
  localparam int TICKS_PER_DAY = 1440;
  localparam int TEN_W         = $clog2(TICKS_PER_ADD);
  localparam int HADD_W        = $clog2(ADDS_PER_HOUR);
  localparam int DADD_W        = $clog2(ADDS_PER_DADD);

  // Command and history select codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [PLOT_W-1:0] PLOT_MINUTE = 2'd0;
  localparam logic [PLOT_W-1:0] PLOT_HOUR   = 2'd1;
  localparam logic [PLOT_W-1:0] PLOT_DAY    = 2'd2;

  // Control that travels down the pipeline with each item
  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic              add_h;
    logic              add_d;
    logic              push_h;
    logic              push_d;
    logic [PLOT_W-1:0] plot;
    logic [CH_W-1:0]   rd_ch;
    logic [POS_W-1:0]  pos;
  } ctl_t;

  // One result item held in a chain slot
  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] minute_value;
    logic                    hour_valid;
    logic signed [VAL_W-1:0] hour_value;
    logic                    day_valid;
    logic signed [VAL_W-1:0] day_value;
    logic signed [VAL_W-1:0] read_value;
    logic                    last;
  } res_t;

endpackage

// ----- design/mrtl_cell.sv -----
module mrtl_cell (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [mrtl_pkg::CH_W-1:0]                 ch_id,
  input  logic                                      adv,
  input  logic                                      shift,
  input  mrtl_pkg::ctl_t                            ctl2,
  input  mrtl_pkg::ctl_t                            ctl3,
  input  logic signed [mrtl_pkg::SAMPLE_W-1:0]      sample,
  input  mrtl_pkg::res_t                            read_res,
  input  mrtl_pkg::res_t                            neighbor,
  output mrtl_pkg::res_t                            slot,
  output logic signed [mrtl_pkg::VAL_W-1:0]         rd_entry
);
  import mrtl_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SCALED_W-1:0] prod7;
  logic signed [SCALED_W-1:0] biased;
  logic signed [VAL_W-1:0]    scaled_q;
  logic signed [VAL_W-1:0]    minute_q;
  logic signed [SUM_W-1:0]    hour_sum;
  logic signed [SUM_W-1:0]    day_sum;
  logic signed [SUM_W-1:0]    total_h;
  logic signed [SUM_W-1:0]    total_d;
  logic                       hsign;
  logic                       dsign;
  logic [ABS_W-1:0]           habs;
  logic [ABS_W-1:0]           dabs;
  logic [PROD_W-1:0]          hprod;
  logic [PROD_W-1:0]          dprod;
  logic signed [VAL_W-1:0]    hq;
  logic signed [VAL_W-1:0]    dq;
  logic signed [VAL_W-1:0]    hv;
  logic signed [VAL_W-1:0]    dv;
  logic signed [VAL_W-1:0]    min_hist  [HISTORY_DEPTH];
  logic signed [VAL_W-1:0]    hour_hist [HISTORY_DEPTH];
  logic signed [VAL_W-1:0]    day_hist  [HISTORY_DEPTH];
  logic [HIST_IDX_W-1:0]      rd_idx;
  logic                       load;
  logic                       tick2;
  logic                       tick3;
  res_t                       own;

  assign load  = adv && ctl3.vld;
  assign tick2 = adv && ctl2.vld && (ctl2.cmd == CMD_TICK);
  assign tick3 = load && (ctl3.cmd == CMD_TICK);

  // Capture the sample with the item
  always_ff @(posedge clk) begin
    if (adv) begin
      sample_q <= sample;
    end
  end

  // Scale by 7/16, rounding toward zero
  assign prod7  = SCALED_W'(sample_q) * SCALED_W'(SCALE_MUL);
  assign biased = prod7[SCALED_W-1] ? prod7 + SCALED_W'(SCALE_BIAS) : prod7;

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_q <= VAL_W'(biased >>> SCALE_SHIFT);
    end
  end

  // Accumulate sums and split the running totals into sign and magnitude
  assign total_h = hour_sum + (ctl2.add_h ? SUM_W'(scaled_q) : '0);
  assign total_d = day_sum + (ctl2.add_d ? SUM_W'(scaled_q) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_sum <= '0;
      day_sum  <= '0;
    end else if (tick2) begin
      if (ctl2.add_h) begin
        hour_sum <= ctl2.push_h ? '0 : total_h;
      end
      if (ctl2.add_d) begin
        day_sum <= ctl2.push_d ? '0 : total_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      minute_q <= scaled_q;
      hsign    <= total_h[SUM_W-1];
      dsign    <= total_d[SUM_W-1];
      habs     <= total_h[SUM_W-1] ? ABS_W'(-total_h) : ABS_W'(total_h);
      dabs     <= total_d[SUM_W-1] ? ABS_W'(-total_d) : ABS_W'(total_d);
    end
  end

  // Divide the magnitudes by six and restore the sign
  assign hprod = PROD_W'(habs) * PROD_W'(DIV6_RECIP);
  assign dprod = PROD_W'(dabs) * PROD_W'(DIV6_RECIP);
  assign hq    = hprod[AVG_SHIFT +: VAL_W];
  assign dq    = dprod[AVG_SHIFT +: VAL_W];
  assign hv    = hsign ? -hq : hq;
  assign dv    = dsign ? -dq : dq;

  // Shift new entries into the histories, oldest at position zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        min_hist[j]  <= '0;
        hour_hist[j] <= '0;
        day_hist[j]  <= '0;
      end
    end else if (tick3) begin
      for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
        min_hist[j] <= min_hist[j+1];
      end
      min_hist[HISTORY_DEPTH-1] <= minute_q;
      if (ctl3.push_h) begin
        for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
          hour_hist[j] <= hour_hist[j+1];
        end
        hour_hist[HISTORY_DEPTH-1] <= hv;
      end
      if (ctl3.push_d) begin
        for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
          day_hist[j] <= day_hist[j+1];
        end
        day_hist[HISTORY_DEPTH-1] <= dv;
      end
    end
  end

  // Pick the requested entry for a read
  assign rd_idx = HIST_IDX_W'(ctl3.pos);

  always_comb begin
    rd_entry = '0;
    if (int'(ctl3.pos) < HISTORY_DEPTH) begin
      case (ctl3.plot)
        PLOT_MINUTE: rd_entry = min_hist[rd_idx];
        PLOT_HOUR:   rd_entry = hour_hist[rd_idx];
        PLOT_DAY:    rd_entry = day_hist[rd_idx];
        default:     rd_entry = '0;
      endcase
    end
  end

  // Build this channel's tick result
  always_comb begin
    own              = '0;
    own.channel      = ch_id;
    own.minute_value = minute_q;
    own.hour_valid   = ctl3.push_h;
    own.hour_value   = ctl3.push_h ? hv : '0;
    own.day_valid    = ctl3.push_d;
    own.day_value    = ctl3.push_d ? dv : '0;
    own.last         = (ch_id == CH_W'(CHANNELS - 1));
  end

  // Load on a new item, otherwise advance toward the output on a transfer
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= (ctl3.cmd == CMD_READ) ? read_res : own;
    end else if (shift) begin
      slot <= neighbor;
    end
  end

endmodule

// ----- design/multi_rate_trend_logger.sv -----
// Multi-rate trend logger for six sensor channels.
// Slave channel: one item per transfer. tuser bit 0 selects a minute tick
// (samples in tdata) or a read of one history entry (plot_select in tuser,
// read_channel and read_position in tdata).
// Master channel: a tick gives six results, channel 0 first, tlast on
// channel 5; a read gives one result with tlast set.
// Each channel has its own cell holding its scaled sample, hour and day
// sums and three 15-entry histories. Items run through three pipeline
// stages (capture, scale, sum) and then load the row of cell result slots
// in parallel; the slots shift toward cell 0, one result per cycle while m_tready is high.
// Throughput: ticks are limited by draining the six slots through the single
// master port; reads go one per cycle while m_tready is high. A new item is
// taken while the previous results are still draining.
// Master stall: the slots hold, and once the last stage waits on an occupied
// row the whole pipeline and s_tready hold low.
// Reset clears the tick counters, all sums and histories, and the
// pipeline; the block takes items on the first cycle after reset.
module multi_rate_trend_logger (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_0..sample_5 [95:0], read_channel [98:96], read_position [102:99]
  input  logic [mrtl_pkg::S_DATA_W-1:0]     s_tdata,
  // cmd [0], plot_select [2:1]
  input  logic [mrtl_pkg::S_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // channel [2:0], minute_value [17:3], hour_value [32:18],
  // day_value [47:33], read_value [62:48]
  output logic [mrtl_pkg::M_DATA_W-1:0]     m_tdata,
  // hour_valid [0], day_valid [1]
  output logic [mrtl_pkg::M_USER_W-1:0]     m_tuser,
  output logic                              m_tlast
);
  import mrtl_pkg::*;

  logic [TICK_W-1:0]       tick_count;
  logic [TEN_W-1:0]        cnt10;
  logic [HADD_W-1:0]       hadd_cnt;
  logic [DADD_W-1:0]       dadd_cnt;
  logic [CNT_W-1:0]        cnt;
  ctl_t                    ctl_in;
  ctl_t                    ctl1;
  ctl_t                    ctl2;
  ctl_t                    ctl3;
  logic                    adv;
  logic                    load_ok;
  logic                    load;
  logic                    shift;
  logic                    tick_acc;
  logic                    add_h;
  logic                    add_d;
  logic                    push_h;
  logic                    push_d;
  res_t                    slots   [CHANNELS];
  res_t                    nbr     [CHANNELS];
  logic signed [VAL_W-1:0] cell_rd [CHANNELS];
  res_t                    read_res;
  res_t                    head;

  // Flow control: the row loads when empty or when its final result leaves
  assign m_tvalid = (cnt != '0);
  assign shift    = m_tvalid && m_tready;
  assign load_ok  = (cnt == '0) || ((cnt == CNT_W'(1)) && m_tready);
  assign adv      = !ctl3.vld || load_ok;
  assign load     = adv && ctl3.vld;
  assign s_tready = adv;
  assign tick_acc = s_tvalid && adv && (s_tuser[0] == CMD_TICK);

  // Schedule flags for the tick being taken
  assign add_h  = (cnt10 == TEN_W'(TICKS_PER_ADD - 1));
  assign push_h = add_h && (hadd_cnt == HADD_W'(ADDS_PER_HOUR - 1));
  assign add_d  = add_h && (dadd_cnt == DADD_W'(ADDS_PER_DADD - 1));
  assign push_d = (tick_count == TICK_W'(TICKS_PER_DAY - 1));

  // Advance the tick counters; all restart together at the day boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      cnt10      <= '0;
      hadd_cnt   <= '0;
      dadd_cnt   <= '0;
    end else if (tick_acc) begin
      tick_count <= push_d ? '0 : tick_count + TICK_W'(1);
      cnt10      <= add_h ? '0 : cnt10 + TEN_W'(1);
      if (add_h) begin
        hadd_cnt <= push_h ? '0 : hadd_cnt + HADD_W'(1);
        dadd_cnt <= add_d ? '0 : dadd_cnt + DADD_W'(1);
      end
    end
  end

  // Decode the incoming item
  always_comb begin
    ctl_in        = '0;
    ctl_in.vld    = s_tvalid;
    ctl_in.cmd    = s_tuser[0];
    ctl_in.plot   = s_tuser[2:1];
    ctl_in.rd_ch  = s_tdata[RD_CH_LSB +: CH_W];
    ctl_in.pos    = s_tdata[POS_LSB +: POS_W];
    if (s_tuser[0] == CMD_TICK) begin
      ctl_in.add_h  = add_h;
      ctl_in.add_d  = add_d;
      ctl_in.push_h = push_h;
      ctl_in.push_d = push_d;
    end
  end

  // Move control down the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else if (adv) begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  // Track results held in the slot row
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= (ctl3.cmd == CMD_READ) ? CNT_W'(1) : CNT_W'(CHANNELS);
    end else if (shift) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Read result from the selected channel
  always_comb begin
    read_res         = '0;
    read_res.channel = ctl3.rd_ch;
    read_res.last    = 1'b1;
    if (int'(ctl3.rd_ch) < CHANNELS) begin
      read_res.read_value = cell_rd[ctl3.rd_ch];
    end
  end

  // Row of channel cells
  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    if (c == CHANNELS - 1) begin : g_end
      assign nbr[c] = '0;
    end else begin : g_mid
      assign nbr[c] = slots[c+1];
    end

    mrtl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ch_id    (CH_W'(c)),
      .adv      (adv),
      .shift    (shift),
      .ctl2     (ctl2),
      .ctl3     (ctl3),
      .sample   (s_tdata[c*SAMPLE_W +: SAMPLE_W]),
      .read_res (read_res),
      .neighbor (nbr[c]),
      .slot     (slots[c]),
      .rd_entry (cell_rd[c])
    );
  end

  // Present the head slot
  assign head    = slots[0];
  assign m_tdata = {1'b0, head.read_value, head.day_value, head.hour_value,
                    head.minute_value, head.channel};
  assign m_tuser = {head.day_valid, head.hour_valid};
  assign m_tlast = head.last;

  // The final result in the row always carries tlast
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (cnt == CNT_W'(1)) |-> m_tlast)
    else $error("final held result lacks tlast");

  // A read loads exactly one result marked last
  a_read_single: assert property (@(posedge clk) disable iff (rst)
    (load && (ctl3.cmd == CMD_READ)) |=> (m_tvalid && m_tlast && (cnt == CNT_W'(1))))
    else $error("read did not load a single last result");

  // The pipeline holds while the last stage waits on a busy row
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl3.vld && (cnt > CNT_W'(1))) |-> !s_tready)
    else $error("input taken while results are still pending");

  // An hour push always comes with an hour add
  a_push_add: assert property (@(posedge clk) disable iff (rst)
    (ctl1.vld && ctl1.push_h) |-> ctl1.add_h)
    else $error("hour push without hour add");

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtl_pkg::*;

  // Code for the one history select that names no history
  localparam logic [PLOT_W-1:0] PLOT_UNUSED = 2'd3;
  localparam int RUN_LIMIT_NS = 25_000_000;
  localparam int MAX_REPORTS  = 200;

  // How a tick fills the samples that go into the sums
  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_e;

  // Tracks the logger's histories and sums and holds the results still due
  class trend_tracker;
    int unsigned tick_cnt;
    int hour_acc [CHANNELS];
    int day_acc [CHANNELS];
    int hist [3][CHANNELS][HISTORY_DEPTH];
    res_t due_results[$];
    int errors;

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function void shift_in(int which, int ch, int v);
      for (int j = 0; j + 1 < HISTORY_DEPTH; j++) hist[which][ch][j] = hist[which][ch][j + 1];
      hist[which][ch][HISTORY_DEPTH - 1] = v;
    endfunction

    // Work out the results of one accepted transfer and advance the state
    function void note_item(logic [S_DATA_W-1:0] data, logic [S_USER_W-1:0] user);
      res_t want;
      logic [PLOT_W-1:0] plot;
      int rc, rp, raw, scaled, hv, dv;
      bit add_h, add_d, push_h, push_d;
      plot = user[PLOT_W:1];
      if (user[0] == CMD_READ) begin
        rc = data[RD_CH_LSB +: CH_W];
        rp = data[POS_LSB +: POS_W];
        want = '0;
        want.channel = CH_W'(rc);
        want.last = 1'b1;
        if (plot <= PLOT_DAY && rc < CHANNELS && rp < HISTORY_DEPTH)
          want.read_value = VAL_W'(hist[plot][rc][rp]);
        due_results.push_back(want);
        return;
      end
      tick_cnt = (tick_cnt + 1) % 2048;
      add_h  = (tick_cnt % 10) == 0;
      add_d  = (tick_cnt % 240) == 0;
      push_h = (tick_cnt % 60) == 0;
      push_d = (tick_cnt % 1440) == 0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        // Scale by 7/16, truncating toward zero
        raw = $signed(data[ch*SAMPLE_W +: SAMPLE_W]);
        scaled = (raw * 7) / 16;
        hv = 0;
        dv = 0;
        shift_in(PLOT_MINUTE, ch, scaled);
        if (add_h) hour_acc[ch] += scaled;
        if (add_d) day_acc[ch] += scaled;
        if (push_h) begin
          hv = hour_acc[ch] / 6;
          shift_in(PLOT_HOUR, ch, hv);
          hour_acc[ch] = 0;
        end
        if (push_d) begin
          dv = day_acc[ch] / 6;
          shift_in(PLOT_DAY, ch, dv);
          day_acc[ch] = 0;
        end
        want = '0;
        want.channel = CH_W'(ch);
        want.minute_value = VAL_W'(scaled);
        want.hour_valid = push_h;
        want.hour_value = VAL_W'(hv);
        want.day_valid = push_d;
        want.day_value = VAL_W'(dv);
        want.last = (ch == CHANNELS - 1);
        due_results.push_back(want);
      end
      if (push_d) tick_cnt = 0;
    endfunction

    // Compare one result transfer with the oldest one due
    task check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user, logic last);
      res_t want;
      if (due_results.size() == 0) begin
        report("result transfer with nothing due");
        return;
      end
      want = due_results.pop_front();
      check_field("channel", data[2:0], want.channel);
      check_field("minute_value", $signed(data[17:3]), want.minute_value);
      check_field("hour_value", $signed(data[32:18]), want.hour_value);
      check_field("day_value", $signed(data[47:33]), want.day_value);
      check_field("read_value", $signed(data[62:48]), want.read_value);
      check_field("hour_valid", user[0], want.hour_valid);
      check_field("day_valid", user[1], want.day_valid);
      check_field("last", last, want.last);
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;

  bit idling = 1'b1;
  trend_tracker tracker = new();

  multi_rate_trend_logger i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL multi_rate_trend_logger");
    $finish;
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Hold one item on the input until it transfers, after an optional gap
  task automatic send_item(input logic [S_DATA_W-1:0] data, input logic [S_USER_W-1:0] user);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= user;
    do @(posedge clk); while (!s_tready);
    tracker.note_item(data, user);
  endtask

  // Samples packed channel 0 lowest; read fields and select carry noise
  task automatic send_tick(input logic [CHANNELS*SAMPLE_W-1:0] smp);
    send_item({1'b0, POS_W'($urandom), CH_W'($urandom), smp},
              {PLOT_W'($urandom), CMD_TICK});
  endtask

  task automatic send_read(input logic [PLOT_W-1:0] plot, input logic [CH_W-1:0] rc,
                           input logic [POS_W-1:0] rp);
    send_item({1'b0, rp, rc, $urandom, $urandom, $urandom}, {plot, CMD_READ});
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(fill_e fill);
    logic [SAMPLE_W-1:0] corners [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                         16'h0001, 16'hFFF1};
    case (fill)
      FILL_MAX: return 16'h7FFF;
      FILL_MIN: return 16'h8000;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: return corners[$urandom_range(0, 5)];
      1: return SAMPLE_W'($urandom_range(0, 63)) - 16'd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Fill the samples; ticks that feed the sums may be pinned to one extreme
  task automatic send_random_tick(input fill_e hour_fill, input fill_e day_fill);
    logic [CHANNELS*SAMPLE_W-1:0] smp;
    int unsigned nxt;
    fill_e fill;
    nxt = tracker.tick_cnt + 1;
    fill = FILL_RANDOM;
    if (nxt % 240 == 0 && day_fill != FILL_RANDOM) fill = day_fill;
    else if (nxt % 10 == 0) fill = hour_fill;
    for (int ch = 0; ch < CHANNELS; ch++) smp[ch*SAMPLE_W +: SAMPLE_W] = pick_sample(fill);
    send_tick(smp);
  endtask

  // Mostly valid reads, now and then an unused select, channel or position
  task automatic send_random_read();
    logic [PLOT_W-1:0] plot;
    logic [CH_W-1:0] rc;
    logic [POS_W-1:0] rp;
    plot = ($urandom_range(0, 9) == 0) ? PLOT_UNUSED : PLOT_W'($urandom_range(0, 2));
    rc = ($urandom_range(0, 7) == 0) ? CH_W'($urandom_range(CHANNELS, 7))
                                     : CH_W'($urandom_range(0, CHANNELS - 1));
    rp = ($urandom_range(0, 7) == 0) ? POS_W'((1 << POS_W) - 1)
                                     : POS_W'($urandom_range(0, HISTORY_DEPTH - 1));
    send_read(plot, rc, rp);
  endtask

  task automatic run_mixed(input int count, inout fill_e hour_fill, inout fill_e day_fill);
    for (int n = 0; n < count; n++) begin
      if (tracker.tick_cnt % 60 == 0) begin
        hour_fill = fill_e'($urandom_range(0, 4));
        if (hour_fill > FILL_MIN) hour_fill = FILL_RANDOM;
      end
      if (tracker.tick_cnt == 0) day_fill = fill_e'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) send_random_read();
      else send_random_tick(hour_fill, day_fill);
    end
  endtask

  initial begin
    fill_e hour_fill;
    fill_e day_fill;
    int sent;
    hour_fill = FILL_RANDOM;
    day_fill = FILL_RANDOM;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reads of cleared histories
    send_read(PLOT_MINUTE, 3'd0, 4'd14);
    send_read(PLOT_HOUR, 3'd5, 4'd0);
    send_read(PLOT_DAY, 3'd2, 4'd7);
    // Sample extremes and truncation of negative values
    send_tick({16'hFFEF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF});
    send_tick({16'h8001, 16'h7FF0, 16'hFFFE, 16'h0002, 16'hFFF0, 16'h0010});
    send_tick({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    // Newest and older entries, every out-of-range case, then hour and day entries
    send_read(PLOT_MINUTE, 3'd0, 4'd14);
    send_read(PLOT_MINUTE, 3'd1, 4'd13);
    send_read(PLOT_MINUTE, 3'd5, 4'd12);
    send_read(PLOT_MINUTE, 3'd4, 4'd11);
    send_read(PLOT_MINUTE, 3'd0, 4'd15);
    send_read(PLOT_MINUTE, 3'd6, 4'd14);
    send_read(PLOT_MINUTE, 3'd7, 4'd14);
    send_read(PLOT_UNUSED, 3'd0, 4'd14);
    send_read(PLOT_HOUR, 3'd2, 4'd14);
    send_read(PLOT_DAY, 3'd3, 4'd14);

    // Random mix in chunks, each with its own idling
    while (sent < 160) begin
      idling = ($urandom_range(0, 3) != 0);
      run_mixed(40, hour_fill, day_fill);
      sent += 40;
    end

    // Closing stretch at full rate on both sides
    idling = 1'b0;
    run_mixed(150, hour_fill, day_fill);
    s_tvalid <= 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) $display("PASS multi_rate_trend_logger");
    else $display("FAIL multi_rate_trend_logger");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mrtl_pkg.sv
design/mrtl_cell.sv
design/multi_rate_trend_logger.sv
bench/tb.sv
